[src/dtd_pkg.sv]
// Package for the decimal text to double converter.
// Holds widths, character codes, double constants, the sequencer state type and the
// rounding helpers. Depends on nothing.
package dtd_pkg;

	localparam int CHAR_W                  = 8;
	localparam int VALUE_W                 = 64;
	localparam int DEF_MAX_EXPONENT_MAG    = 4095;
	localparam int DEF_MAX_FRACTION_DIGITS = 4095;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_EXP   = 8'h65;
	localparam logic [7:0] CH_CASE  = 8'h20;

	localparam int SIG_W  = 53;
	localparam int PROD_W = 106;
	localparam int SHW    = 108;

	// Significands and biased exponent fields of 10.0 and of the double nearest 0.1.
	localparam logic [52:0] SIG_TEN    = 53'h14000000000000;
	localparam logic [52:0] SIG_TENTH  = 53'h1999999999999A;
	localparam logic [10:0] EXPF_TEN   = 11'd1026;
	localparam logic [10:0] EXPF_TENTH = 11'd1019;
	localparam logic [10:0] EXPF_MAX   = 11'h7ff;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_MRND,
		ST_ADD1,
		ST_ADD2,
		ST_CHECK,
		ST_SCALE,
		ST_DONE
	} dtd_state_t;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_EXP
	} dtd_phase_t;

	// Round to nearest even and pack. e_in is the biased exponent that belongs to a
	// significand with its leading one at bit 52 (at least one).
	function automatic logic [63:0] round_pack(input logic sgn, input logic [12:0] e_in,
			input logic [52:0] mant, input logic guard, input logic sticky);
		logic        inc;
		logic [53:0] mr;
		logic [52:0] m2;
		logic [12:0] e2;
		logic [12:0] fld;
		inc = guard & (sticky | mant[0]);
		mr  = {1'b0, mant} + {53'd0, inc};
		if (mr[53]) begin
			m2 = {1'b1, 52'd0};
			e2 = e_in + 13'd1;
		end else begin
			m2 = mr[52:0];
			e2 = e_in;
		end
		fld = e2 - 13'd1 + {12'd0, m2[52]};
		if (fld >= 13'd2047)
			round_pack = {sgn, EXPF_MAX, 52'd0};
		else
			round_pack = {sgn, fld[10:0], m2[51:0]};
	endfunction

	// Exact double of a small non-negative integer.
	function automatic logic [63:0] small_to_double(input logic [3:0] n);
		logic [1:0]  b;
		logic [55:0] m;
		b = n[3] ? 2'd3 : (n[2] ? 2'd2 : (n[1] ? 2'd1 : 2'd0));
		m = {52'd0, n} << (6'd52 - {4'd0, b});
		if (n == 4'd0)
			small_to_double = 64'd0;
		else
			small_to_double = {1'b0, 11'd1023 + {9'd0, b}, m[51:0]};
	endfunction

endpackage

[src/dtd_char_if.sv]
// Handshake channel for the character stream of the converter.
// Depends on dtd_pkg for the character width.
interface dtd_char_if import dtd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;
	modport source(output valid, output char_code, output last_char, input ready);
	modport sink(input valid, input char_code, input last_char, output ready);
endinterface

[src/dtd_value_if.sv]
// Handshake channel for the converted double of the converter.
// Depends on dtd_pkg for the value width.
interface dtd_value_if import dtd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value_bits;
	modport source(output valid, output value_bits, input ready);
	modport sink(input valid, input value_bits, output ready);
endinterface

[src/decimal_text_to_double_top.sv]
// Decimal text to IEEE 754 double converter, one character per transaction.
// Depends on dtd_pkg, dtd_char_if and dtd_value_if.
// For a folded digit the value is multiplied by ten and the digit added before the next
// ready; a marker or an ignored character is only decoded. The last character adds a
// scaling pass per power of ten (|exponent - fraction count|, saturated); a stalled result
// holds. Throughput is set by the single shared 27x27 multiplier that builds each double
// product from four partial products. Reset (arst_n low) clears all control state at once.
module decimal_text_to_double_top import dtd_pkg::*; #(
	parameter int MAX_EXPONENT_MAG    = DEF_MAX_EXPONENT_MAG,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	dtd_char_if.sink   chars,
	dtd_value_if.source result
);

	// The exponent accumulator saturates at the sum of both bounds, which keeps the
	// final saturation exact. Widths follow from the bounds.
	localparam int EACC_CAP = MAX_EXPONENT_MAG + MAX_FRACTION_DIGITS;
	localparam int EW       = $clog2(EACC_CAP + 1);
	localparam int FW       = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int CW       = $clog2(MAX_EXPONENT_MAG + 1);
	localparam int PW       = EW + 2;

	dtd_state_t state_q, state_d;

	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [VALUE_W-1:0] acc_q;
	dtd_phase_t         phase_q;
	logic               at_start_q;
	logic               vneg_q;
	logic               after_marker_q;
	logic               eneg_q;
	logic [EW-1:0]      eacc_q;
	logic [FW-1:0]      frac_q;

	// Shared multiplier state.
	logic               tenth_q;
	logic               scaling_q;
	logic [2:0]         pcnt_q;
	logic [53:0]        pp_q;
	logic [1:0]         ppsh_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CW-1:0]      cnt_q;

	// Adder state between its align and its round cycle.
	logic [57:0]        sum_q;
	logic               sumst_q;
	logic [10:0]        sume_q;
	logic               addsp_q;
	logic [VALUE_W-1:0] addspv_q;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_q;

	logic chars_ready;
	logic out_free;
	logic done_fire;

	// Character decode.
	logic       is_minus, is_dot, is_e, frac_lt, fold;
	logic [3:0] nib;

	assign nib      = char_q[3:0];
	assign is_minus = (char_q == CH_MINUS);
	assign is_dot   = (char_q == CH_DOT);
	assign is_e     = ((char_q | CH_CASE) == CH_EXP);
	assign frac_lt  = (frac_q < FW'(MAX_FRACTION_DIGITS));

	always_comb begin
		fold = 1'b0;
		if (!(at_start_q && is_minus)) begin
			case (phase_q)
				PH_INT:  fold = !is_dot && !is_e;
				PH_FRAC: fold = !is_e && frac_lt;
				default: fold = 1'b0;
			endcase
		end
	end

	// Exponent digit: acc*10 + nibble, saturated.
	logic [EW+3:0] e10;
	logic [EW-1:0] eacc_next;
	always_comb begin
		e10 = ({4'd0, eacc_q} << 3) + ({4'd0, eacc_q} << 1) + {{EW{1'b0}}, nib};
		if (e10 > (EW+4)'(EACC_CAP))
			eacc_next = EW'(EACC_CAP);
		else
			eacc_next = e10[EW-1:0];
	end

	// Final power of ten: exponent minus fraction count, saturated.
	logic signed [PW-1:0] pval;
	logic [CW-1:0]        pmag;
	always_comb begin
		pval = (eneg_q ? -$signed({2'b00, eacc_q}) : $signed({2'b00, eacc_q}))
			- $signed({{(PW-FW){1'b0}}, frac_q});
		if (pval > $signed(PW'(MAX_EXPONENT_MAG)))
			pmag = CW'(MAX_EXPONENT_MAG);
		else if (pval < -$signed(PW'(MAX_EXPONENT_MAG)))
			pmag = CW'(MAX_EXPONENT_MAG);
		else if (pval < 0)
			pmag = CW'(-pval);
		else
			pmag = CW'(pval);
	end

	// Partial products: the 53-bit significands are split 26/27 bits, one 27x27 product
	// per cycle, added into the 106-bit product in the cycle after.
	logic [52:0]       mx, bsig;
	logic [26:0]       mul_a, mul_b;
	logic [1:0]        mul_sh;
	logic [PROD_W-1:0] pp_ext;

	assign mx   = {acc_q[62:52] != 11'd0, acc_q[51:0]};
	assign bsig = tenth_q ? SIG_TENTH : SIG_TEN;

	always_comb begin
		case (pcnt_q[1:0])
			2'd0: begin mul_a = {1'b0, mx[25:0]}; mul_b = {1'b0, bsig[25:0]}; mul_sh = 2'd0; end
			2'd1: begin mul_a = {1'b0, mx[25:0]}; mul_b = bsig[52:26];        mul_sh = 2'd1; end
			2'd2: begin mul_a = mx[52:26];        mul_b = {1'b0, bsig[25:0]}; mul_sh = 2'd1; end
			default: begin mul_a = mx[52:26];     mul_b = bsig[52:26];        mul_sh = 2'd2; end
		endcase
		case (ppsh_q)
			2'd0:    pp_ext = {52'd0, pp_q};
			2'd1:    pp_ext = {26'd0, pp_q, 26'd0};
			2'd2:    pp_ext = {pp_q, 52'd0};
			default: pp_ext = '0;
		endcase
	end

	// Product rounding. A subnormal operand only ever meets 0.1, so its result is
	// subnormal too and goes straight to the fixed subnormal scale.
	logic [10:0]              m_ex, m_ec;
	logic signed [13:0]       m_exeff, m_es, m_er, m_e, m_sh;
	logic [6:0]               m_shc;
	logic [PROD_W+SHW-1:0]    m_wide;
	logic [VALUE_W-1:0]       mres;
	always_comb begin
		m_ex    = acc_q[62:52];
		m_ec    = tenth_q ? EXPF_TENTH : EXPF_TEN;
		m_exeff = (m_ex == 11'd0) ? 14'sd1 : $signed({3'b000, m_ex});
		m_es    = m_exeff + $signed({3'b000, m_ec});
		m_er    = (m_ex != 11'd0) ? (m_es - 14'sd1023 + $signed({13'd0, prod_q[PROD_W-1]}))
			: 14'sd0;
		m_e     = (m_er >= 14'sd1) ? m_er : 14'sd1;
		m_sh    = m_e + 14'sd1075 - m_es;
		m_shc   = (m_sh > 14'sd108) ? 7'd108 : m_sh[6:0];
		m_wide  = {prod_q, {SHW{1'b0}}} >> m_shc;
		if (m_ex == EXPF_MAX)
			mres = {acc_q[63], EXPF_MAX, 52'd0};
		else if (m_ex == 11'd0 && acc_q[51:0] == 52'd0)
			mres = {acc_q[63], 63'd0};
		else
			mres = round_pack(acc_q[63], m_e[12:0], m_wide[SHW+52:SHW], m_wide[SHW-1],
				|m_wide[SHW-2:0]);
	end

	// Adder align. The product is zero, infinite or an integer of at least ten, so
	// its exponent is never below that of the nibble.
	logic [10:0]        a_e;
	logic signed [12:0] a_d, a_s;
	logic [57:0]        a_sa, a_sb;
	logic               a_st;
	always_comb begin
		a_e  = acc_q[62:52];
		a_sa = {2'b00, 1'b1, acc_q[51:0], 3'b000};
		a_d  = 13'sd1078 - $signed({2'b00, a_e});
		a_s  = -a_d;
		a_sb = '0;
		a_st = 1'b0;
		if (a_d >= 0) begin
			a_sb = {54'd0, nib} << a_d[5:0];
		end else if (a_s >= 13'sd4) begin
			a_st = |nib;
		end else begin
			case (a_s[1:0])
				2'd1:    begin a_sb = {55'd0, nib[3:1]}; a_st = nib[0];    end
				2'd2:    begin a_sb = {56'd0, nib[3:2]}; a_st = |nib[1:0]; end
				default: begin a_sb = {57'd0, nib[3]};   a_st = |nib[2:0]; end
			endcase
		end
	end

	// Adder normalise and round.
	logic [VALUE_W-1:0] ares;
	always_comb begin
		if (addsp_q)
			ares = addspv_q;
		else if (sum_q[56])
			ares = round_pack(1'b0, {2'b00, sume_q} + 13'd1, sum_q[56:4], sum_q[3],
				(|sum_q[2:0]) | sumst_q);
		else
			ares = round_pack(1'b0, {2'b00, sume_q}, sum_q[55:3], sum_q[2],
				(|sum_q[1:0]) | sumst_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (chars.valid) state_d = ST_DECODE;
			ST_DECODE: state_d = fold ? ST_MUL : ST_CHECK;
			ST_MUL:    if (pcnt_q == 3'd4) state_d = ST_MRND;
			ST_MRND:   state_d = scaling_q ? ST_SCALE : ST_ADD1;
			ST_ADD1:   state_d = ST_ADD2;
			ST_ADD2:   state_d = ST_CHECK;
			ST_CHECK:  state_d = last_q ? ST_SCALE : ST_IDLE;
			ST_SCALE:  state_d = (cnt_q == '0) ? ST_DONE : ST_MUL;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		chars_ready = (state_q == ST_IDLE);
		out_free    = !out_valid_q || result.ready;
		done_fire   = (state_q == ST_DONE) && out_free;
	end

	assign chars.ready       = chars_ready;
	assign result.valid      = out_valid_q;
	assign result.value_bits = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Control state of the parse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			phase_q        <= PH_INT;
			at_start_q     <= 1'b1;
			vneg_q         <= 1'b0;
			after_marker_q <= 1'b0;
			eneg_q         <= 1'b0;
			eacc_q         <= '0;
			frac_q         <= '0;
			tenth_q        <= 1'b0;
			scaling_q      <= 1'b0;
			pcnt_q         <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (done_fire)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_DECODE: begin
					at_start_q <= 1'b0;
					pcnt_q     <= '0;
					tenth_q    <= 1'b0;
					scaling_q  <= 1'b0;
					if (at_start_q && is_minus) begin
						vneg_q <= 1'b1;
					end else begin
						case (phase_q)
							PH_INT: begin
								if (is_dot) begin
									phase_q <= PH_FRAC;
								end else if (is_e) begin
									phase_q        <= PH_EXP;
									after_marker_q <= 1'b1;
								end
							end
							PH_FRAC: begin
								if (is_e) begin
									phase_q        <= PH_EXP;
									after_marker_q <= 1'b1;
								end else if (frac_lt) begin
									frac_q <= frac_q + FW'(1);
								end
							end
							default: begin
								after_marker_q <= 1'b0;
								if (after_marker_q && is_minus)
									eneg_q <= 1'b1;
								else
									eacc_q <= eacc_next;
							end
						endcase
					end
				end
				ST_MUL:   pcnt_q <= pcnt_q + 3'd1;
				ST_MRND: begin
					acc_q <= mres;
					if (scaling_q)
						cnt_q <= cnt_q - CW'(1);
				end
				ST_ADD2:  acc_q <= ares;
				ST_CHECK: begin
					if (last_q) begin
						acc_q[63] <= acc_q[63] ^ vneg_q;
						cnt_q     <= pmag;
						tenth_q   <= (pval < 0);
						scaling_q <= 1'b1;
					end
				end
				ST_SCALE: pcnt_q <= '0;
				ST_DONE: begin
					if (out_free) begin
						acc_q          <= '0;
						phase_q        <= PH_INT;
						at_start_q     <= 1'b1;
						vneg_q         <= 1'b0;
						after_marker_q <= 1'b0;
						eneg_q         <= 1'b0;
						eacc_q         <= '0;
						frac_q         <= '0;
						scaling_q      <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && chars.valid) begin
			char_q <= chars.char_code;
			last_q <= chars.last_char;
		end
		if (state_q == ST_MUL) begin
			if (pcnt_q != 3'd4) begin
				pp_q   <= {27'd0, mul_a} * {27'd0, mul_b};
				ppsh_q <= mul_sh;
			end
			if (pcnt_q == 3'd0)
				prod_q <= '0;
			else
				prod_q <= prod_q + pp_ext;
		end
		if (state_q == ST_ADD1) begin
			sum_q    <= a_sa + a_sb;
			sumst_q  <= a_st;
			sume_q   <= a_e;
			addsp_q  <= (a_e == EXPF_MAX) || (a_e == 11'd0);
			addspv_q <= (a_e == EXPF_MAX) ? acc_q : small_to_double(nib);
		end
		if (done_fire)
			out_q <= acc_q;
	end

endmodule

[src/dtd_checker.sv]
// Port-level checker for the decimal text to double converter, with its bind.
// Depends on dtd_pkg and on the ports of decimal_text_to_double_top.
module dtd_checker import dtd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [VALUE_W-1:0] out_bits
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_bits))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("character taken while previous one still in work");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared directly after a character transaction");

endmodule

bind decimal_text_to_double_top dtd_checker u_dtd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (chars.valid),
	.in_ready (chars.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_bits (result.value_bits)
);
